[rtl/core/hcbm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Handheld cartridge bank mapper package
// Field widths, access kind codes, bus region codes and register reset values.
// ----------------------------------------------------------------------------
package hcbm_pkg;

    localparam int unsigned BUS_ADDR_W = 16;
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned MEM_ADDR_W = 23;
    localparam int unsigned BASE_W     = 6;
    localparam int unsigned BANK_W     = 8;

    // Bits of the bus address that stay inside one 16 KiB ROM window or 8 KiB RAM page.
    localparam int unsigned ROM_OFS_W  = 14;
    localparam int unsigned RAM_OFS_W  = 13;

    // ROM window index width: base + bank + 2 reaches 320 at most.
    localparam int unsigned ROM_IDX_W  = MEM_ADDR_W - ROM_OFS_W;

    // Mapped ROM starts two windows up (0x8000).
    localparam logic [ROM_IDX_W-1:0] ROM_MAPPED_START = ROM_IDX_W'(2);

    localparam logic [BANK_W-1:0] ROM_BANK_RESET = BANK_W'(1);

    // Lower nibble pattern that enables the RAM.
    localparam logic [3:0] RAM_ENABLE_KEY = 4'hA;

    typedef enum logic [1:0] {
        KIND_NONE      = 2'd0,
        KIND_ROM_READ  = 2'd1,
        KIND_RAM_READ  = 2'd2,
        KIND_RAM_WRITE = 2'd3
    } t_access_kind;

    // Top three address bits split the bus into 8 KiB regions.
    localparam logic [2:0] RGN_MODE_ENABLE = 3'd0;
    localparam logic [2:0] RGN_BASE_BANK   = 3'd1;
    localparam logic [2:0] RGN_RAM_BANK    = 3'd2;
    localparam logic [2:0] RGN_EXT_RAM     = 3'd5;

    localparam logic FUNC_READ  = 1'b0;
    localparam logic FUNC_WRITE = 1'b1;

endpackage

[rtl/core/hcbm_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Handheld cartridge bank mapper channels
// Valid/ready channels for bus access beats and mapped memory access beats.
// ----------------------------------------------------------------------------
interface hcbm_req_if
    import hcbm_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic                  func;
    logic [BUS_ADDR_W-1:0] bus_address;
    logic [BYTE_W-1:0]     write_byte;

    modport source (output valid, output func, output bus_address, output write_byte,
                    input ready);
    modport sink   (input valid, input func, input bus_address, input write_byte,
                    output ready);
endinterface

interface hcbm_rsp_if
    import hcbm_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [1:0]            access_kind;
    logic [MEM_ADDR_W-1:0] memory_address;
    logic [BYTE_W-1:0]     ram_write_byte;

    modport source (output valid, output access_kind, output memory_address,
                    output ram_write_byte, input ready);
    modport sink   (input valid, input access_kind, input memory_address,
                    input ram_write_byte, output ready);
endinterface

[rtl/core/handheld_cart_bank_mapper_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Handheld cartridge bank mapper
// Maps CPU bus accesses onto physical ROM and RAM addresses.
// ----------------------------------------------------------------------------
// An accepted bus access beat is captured in the input register and its translation
// in the result register, which holds it until taken. Throughput: one bus access per
// cycle unless the result stalls; the mapper registers are updated in the same cycle
// that an access is translated, so the next access sees them at once.
// Reset: synchronous, active low; unmapped mode, RAM disabled, ROM bank 1,
// base window and RAM bank 0, both pipeline stages empty.
module handheld_cart_bank_mapper_unit
    import hcbm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    hcbm_req_if.sink   i_req,
    hcbm_rsp_if.source o_rsp
);

    // ------------------------------------------------------------------
    // Pipeline control. The result register moves when empty or taken;
    // the input register moves when empty or when the result register
    // does, so a waiting result blocks new beats only if both are full.
    // ------------------------------------------------------------------
    logic r_in_vld;
    logic r_out_vld;
    logic w_advance;
    logic w_process;

    assign w_advance   = !r_out_vld || o_rsp.ready;
    assign i_req.ready = !r_in_vld || w_advance;
    assign w_process   = r_in_vld && w_advance;

    // Input register holding the captured bus access.
    logic                  r_in_func;
    logic [BUS_ADDR_W-1:0] r_in_addr;
    logic [BYTE_W-1:0]     r_in_byte;

    // Mapper registers.
    logic              r_mapped_mode;
    logic [BASE_W-1:0] r_base_window;
    logic              r_ram_enabled;
    logic [BANK_W-1:0] r_rom_bank;
    logic [BANK_W-1:0] r_ram_bank;

    logic              n_mapped_mode;
    logic [BASE_W-1:0] n_base_window;
    logic              n_ram_enabled;
    logic [BANK_W-1:0] n_rom_bank;
    logic [BANK_W-1:0] n_ram_bank;

    // Result register.
    t_access_kind          r_out_kind;
    logic [MEM_ADDR_W-1:0] r_out_addr;
    logic [BYTE_W-1:0]     r_out_byte;

    t_access_kind          n_out_kind;
    logic [MEM_ADDR_W-1:0] n_out_addr;
    logic [BYTE_W-1:0]     n_out_byte;

    // ------------------------------------------------------------------
    // Address translation.
    // ------------------------------------------------------------------
    logic [2:0]            w_region;
    logic [ROM_IDX_W-1:0]  w_rom_idx;
    logic [MEM_ADDR_W-1:0] w_rom_mapped_addr;
    logic [MEM_ADDR_W-1:0] w_ram_addr;
    logic [MEM_ADDR_W-1:0] w_rom_plain_addr;

    assign w_region = r_in_addr[BUS_ADDR_W-1 -: 3];

    // In mapped mode the low half of ROM space uses the base window alone and
    // the high half adds the bank register; both sit two windows up.
    assign w_rom_idx = ROM_MAPPED_START + ROM_IDX_W'(r_base_window)
                     + (r_in_addr[ROM_OFS_W] ? ROM_IDX_W'(r_rom_bank) : '0);
    assign w_rom_mapped_addr = {w_rom_idx, r_in_addr[ROM_OFS_W-1:0]};

    // Unmapped ROM reads pass the 15-bit bus address straight through.
    assign w_rom_plain_addr = MEM_ADDR_W'(r_in_addr[ROM_OFS_W:0]);

    assign w_ram_addr = MEM_ADDR_W'({r_ram_bank, r_in_addr[RAM_OFS_W-1:0]});

    always_comb begin
        n_out_kind    = KIND_NONE;
        n_out_addr    = '0;
        n_out_byte    = '0;
        n_mapped_mode = r_mapped_mode;
        n_base_window = r_base_window;
        n_ram_enabled = r_ram_enabled;
        n_rom_bank    = r_rom_bank;
        n_ram_bank    = r_ram_bank;

        if (r_in_func == FUNC_READ) begin
            if (!r_in_addr[BUS_ADDR_W-1]) begin
                // ROM space, 0x0000-0x7FFF.
                n_out_kind = KIND_ROM_READ;
                n_out_addr = r_mapped_mode ? w_rom_mapped_addr : w_rom_plain_addr;
            end else if (w_region == RGN_EXT_RAM && r_ram_enabled) begin
                n_out_kind = KIND_RAM_READ;
                n_out_addr = w_ram_addr;
            end
        end else begin
            priority if (w_region == RGN_MODE_ENABLE) begin
                // The first write here switches to mapped mode; later ones
                // gate the cartridge RAM.
                if (!r_mapped_mode) begin
                    n_mapped_mode = 1'b1;
                end else begin
                    n_ram_enabled = (r_in_byte[3:0] == RAM_ENABLE_KEY);
                end
            end else if (w_region == RGN_BASE_BANK) begin
                if (!r_mapped_mode) begin
                    n_base_window = r_in_byte[BASE_W-1:0];
                end else begin
                    n_rom_bank = r_in_byte;
                end
            end else if (w_region == RGN_RAM_BANK) begin
                if (r_mapped_mode) begin
                    n_ram_bank = r_in_byte;
                end
            end else if (w_region == RGN_EXT_RAM) begin
                if (r_ram_enabled) begin
                    n_out_kind = KIND_RAM_WRITE;
                    n_out_addr = w_ram_addr;
                    n_out_byte = r_in_byte;
                end
            end else begin
                // Writes anywhere else have no effect.
                n_out_kind = KIND_NONE;
            end
        end
    end

    // ------------------------------------------------------------------
    // Registers.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld      <= 1'b0;
            r_out_vld     <= 1'b0;
            r_mapped_mode <= 1'b0;
            r_base_window <= '0;
            r_ram_enabled <= 1'b0;
            r_rom_bank    <= ROM_BANK_RESET;
            r_ram_bank    <= '0;
        end else begin
            if (i_req.ready) begin
                r_in_vld <= i_req.valid;
            end
            if (w_advance) begin
                r_out_vld <= r_in_vld;
            end
            if (w_process) begin
                r_mapped_mode <= n_mapped_mode;
                r_base_window <= n_base_window;
                r_ram_enabled <= n_ram_enabled;
                r_rom_bank    <= n_rom_bank;
                r_ram_bank    <= n_ram_bank;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_in_func <= i_req.func;
            r_in_addr <= i_req.bus_address;
            r_in_byte <= i_req.write_byte;
        end
        if (w_process) begin
            r_out_kind <= n_out_kind;
            r_out_addr <= n_out_addr;
            r_out_byte <= n_out_byte;
        end
    end

    assign o_rsp.valid          = r_out_vld;
    assign o_rsp.access_kind    = r_out_kind;
    assign o_rsp.memory_address = r_out_addr;
    assign o_rsp.ram_write_byte = r_out_byte;

endmodule
